// File: rtl/dlf_pkg.sv
// ----------------------------------------------------------------------------
// dlf_pkg
// Shared types, constants and step tables for the discounted line fit block.
// ----------------------------------------------------------------------------
package dlf_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned ACC_WIDTH_DEF = 64;

    localparam int unsigned VAL_W     = 32;       // Q16.16 fields
    localparam int unsigned QUOT_W    = VAL_W;
    localparam int unsigned MUL_W     = 32;       // shared multiplier operand width
    localparam int unsigned MAG_W     = 2 * MUL_W;
    localparam int unsigned DISC_W    = 17;
    localparam int unsigned DISC_FRAC = 16;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned SH_W      = 7;        // partial product shift, up to 64 + 16
    localparam int unsigned CNT_W     = 5;

    localparam logic [DISC_W-1:0] DISC_ONE   = 17'h10000;
    localparam logic [DISC_W-1:0] DISC_RESET = 17'd64225;

    localparam int unsigned N_SUMS       = 5;
    localparam int unsigned SCALE_ISSUES = 2 * N_SUMS;
    localparam int unsigned N_WIDE_STEPS = 6;
    localparam int unsigned WIDE_ISSUES  = 4 * N_WIDE_STEPS;
    localparam int unsigned TERM_ISSUES  = 2;

    // sum indexes
    localparam logic [2:0] SI_W  = 3'd0;
    localparam logic [2:0] SI_X  = 3'd1;
    localparam logic [2:0] SI_Y  = 3'd2;
    localparam logic [2:0] SI_XX = 3'd3;
    localparam logic [2:0] SI_XY = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_PRED_Y  = 3'd1,
        OP_PRED_X  = 3'd2,
        OP_PRED_XC = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        REG_DISCOUNT = 2'd0,
        REG_LOCK     = 2'd1,
        REG_SLOPE    = 2'd2,
        REG_ICPT     = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        FS_UPDATED    = 2'd0,
        FS_SINGULAR   = 2'd1,
        FS_LOCKED     = 2'd2,
        FS_NO_READING = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TERMS,
        ST_SCALE,
        ST_WIDE,
        ST_DRAIN,
        ST_DIV_ICPT,
        ST_WAIT_ICPT,
        ST_DIV_SLOPE,
        ST_WAIT_SLOPE,
        ST_PRED_MUL,
        ST_PRED_ADD,
        ST_PRED_DIV,
        ST_WAIT_PRED,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_ITER
    } t_div_state;

    typedef enum logic [1:0] {
        PK_TERM,
        PK_SCALE,
        PK_WIDE,
        PK_PRED
    } t_pkind;

    typedef enum logic [1:0] {
        DST_DET,
        DST_NUMI,
        DST_NUMS
    } t_dest;

    typedef struct packed {
        logic             valid;
        t_pkind           kind;
        logic [2:0]       idx;
        logic             half;
        logic             last;
        logic             neg;
        logic [SH_W-1:0]  shift;
    } t_ptag;

    typedef struct packed {
        logic [2:0] a_idx;
        logic [2:0] b_idx;
        logic       sub;
        logic       fshift;
        t_dest      dest;
        logic       last;
    } t_wstep;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [QUOT_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [VAL_W-1:0] x_value;
        logic signed [VAL_W-1:0] y_value;
        logic signed [VAL_W-1:0] min_limit;
        logic signed [VAL_W-1:0] max_limit;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] fit_slope;
        logic signed [VAL_W-1:0] fit_intercept;
        logic signed [VAL_W-1:0] prediction;
        logic                    prediction_valid;
        logic [1:0]              fit_status;
    } t_out_item;

    // det = W*Sxx - Sx*Sx<<F ; ni = Sy*Sxx - Sx*Sxy ; ns = W*Sxy - Sx*Sy<<F
    function automatic t_wstep wide_step(input logic [2:0] s);
        t_wstep w;
        w = '{a_idx: SI_W, b_idx: SI_XX, sub: 1'b0, fshift: 1'b0, dest: DST_DET, last: 1'b0};
        case (s)
            3'd0: w = '{a_idx: SI_W, b_idx: SI_XX, sub: 1'b0, fshift: 1'b0,
                        dest: DST_DET, last: 1'b0};
            3'd1: w = '{a_idx: SI_X, b_idx: SI_X, sub: 1'b1, fshift: 1'b1,
                        dest: DST_DET, last: 1'b1};
            3'd2: w = '{a_idx: SI_Y, b_idx: SI_XX, sub: 1'b0, fshift: 1'b0,
                        dest: DST_NUMI, last: 1'b0};
            3'd3: w = '{a_idx: SI_X, b_idx: SI_XY, sub: 1'b1, fshift: 1'b0,
                        dest: DST_NUMI, last: 1'b1};
            3'd4: w = '{a_idx: SI_W, b_idx: SI_XY, sub: 1'b0, fshift: 1'b0,
                        dest: DST_NUMS, last: 1'b0};
            3'd5: w = '{a_idx: SI_X, b_idx: SI_Y, sub: 1'b1, fshift: 1'b1,
                        dest: DST_NUMS, last: 1'b1};
            default: ;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/dlf_div.sv
// ----------------------------------------------------------------------------
// dlf_div
// Serial restoring divider: signed wide numerator and divisor, truncating
// quotient saturated to 32 bits. One compare and subtract per cycle.
// ----------------------------------------------------------------------------
module dlf_div #(
    parameter int unsigned WIDE_W = 162
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [WIDE_W-1:0]        i_num,
    input  logic signed [WIDE_W-1:0]        i_den,
    output dlf_pkg::t_div_res               o_res
);
    import dlf_pkg::*;

    localparam int unsigned REM_W = WIDE_W + QUOT_W;
    localparam int unsigned QC_W  = $clog2(QUOT_W);
    localparam logic [QUOT_W-1:0] POS_LIM = {1'b0, {(QUOT_W-1){1'b1}}};
    localparam logic [QUOT_W-1:0] NEG_LIM = {1'b1, {(QUOT_W-1){1'b0}}};

    t_div_state                r_state, n_state;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [REM_W-1:0]          r_dsh, n_dsh;
    logic [QUOT_W-1:0]         r_q, n_q;
    logic [QC_W-1:0]           r_cnt, n_cnt;
    logic                      r_neg, n_neg;
    logic                      r_done, n_done;
    logic signed [QUOT_W-1:0]  r_quot, n_quot;

    logic                      ge;
    logic [REM_W-1:0]          diff;
    logic [WIDE_W-1:0]         num_mag, den_mag;

    assign ge      = r_rem >= r_dsh;
    assign diff    = r_rem - r_dsh;
    assign num_mag = i_num[WIDE_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[WIDE_W-1] ? (~i_den + 1'b1) : i_den;

    function automatic logic [QUOT_W-1:0] finish(input logic [QUOT_W-1:0] q,
                                                 input logic neg, input logic sat);
        logic [QUOT_W-1:0] r;
        if (sat) begin
            r = neg ? NEG_LIM : POS_LIM;
        end else if (neg) begin
            r = (q > NEG_LIM) ? NEG_LIM : (~q + 1'b1);
        end else begin
            r = (q > POS_LIM) ? POS_LIM : q;
        end
        return r;
    endfunction

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_quot  = r_quot;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_rem   = REM_W'(num_mag);
                    n_dsh   = REM_W'(den_mag) << QUOT_W;
                    n_neg   = i_num[WIDE_W-1] ^ i_den[WIDE_W-1];
                    n_q     = '0;
                    n_state = DV_CHECK;
                end
            end
            DV_CHECK: begin
                // quotient of 2^32 or more saturates either way
                if (ge) begin
                    n_quot  = finish(r_q, r_neg, 1'b1);
                    n_done  = 1'b1;
                    n_state = DV_IDLE;
                end else begin
                    n_dsh   = r_dsh >> 1;
                    n_cnt   = QC_W'(QUOT_W - 1);
                    n_state = DV_ITER;
                end
            end
            DV_ITER: begin
                if (ge) begin
                    n_rem = diff;
                    n_q   = r_q | (QUOT_W'(1) << r_cnt);
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_quot  = finish(n_q, r_neg, 1'b0);
                    n_done  = 1'b1;
                    n_state = DV_IDLE;
                end
            end
            default: n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_res = '{busy: (r_state != DV_IDLE), done: r_done, quot: r_quot};

endmodule

// File: rtl/discounted_line_fit_top.sv
// ----------------------------------------------------------------------------
// discounted_line_fit_top
// Exponentially discounted least-squares line fit over (x,y) readings, with
// prediction ops and an APB register port. One 32x32 multiplier and one
// serial divider are shared under a sequencer.
// ----------------------------------------------------------------------------
// Per item: an unlocked reading runs term, discount and wide products
//   on the multiplier, then intercept and slope divisions unless singular;
//   predict y multiplies and adds; predict x divides unless slope is 0.
// One item in flight; the next can be taken in the cycle after the result enters
//   the output register. Synchronous reset restores register defaults and
//   zeroes the sums and fit; no clearing pass.
// ----------------------------------------------------------------------------
module discounted_line_fit_top #(
    parameter int unsigned FRAC_BITS = dlf_pkg::FRAC_BITS_DEF,
    parameter int unsigned ACC_WIDTH = dlf_pkg::ACC_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dlf_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dlf_pkg::t_out_item              o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dlf_pkg::PADDR_W-1:0]     paddr,
    input  logic [dlf_pkg::PDATA_W-1:0]     pwdata,
    output logic [dlf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import dlf_pkg::*;

    localparam int unsigned WIDE_W = 2 * ACC_WIDTH + 2 * FRAC_BITS + 2;
    localparam logic signed [MAG_W:0] ACC_MAX = (MAG_W+1)'((65'sd1 <<< (ACC_WIDTH - 1)) - 1);
    localparam logic signed [MAG_W:0] ACC_MIN = -ACC_MAX - 1;
    localparam logic signed [MAG_W+1:0] V_MAX = (MAG_W+2)'(32'sh7fffffff);
    localparam logic signed [MAG_W+1:0] V_MIN = (MAG_W+2)'(-33'sh80000000);

    // configuration
    logic [DISC_W-1:0]         r_discount;
    logic                      r_lock;
    logic signed [VAL_W-1:0]   r_locked_slope;
    logic signed [VAL_W-1:0]   r_locked_icpt;

    // learned state
    logic signed [ACC_WIDTH-1:0] r_wsum, r_xsum, r_ysum, r_xxsum, r_xysum;
    logic signed [VAL_W-1:0]     r_lslope, r_licpt;

    // sequencer and datapath
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    t_in_item                  r_in;
    logic signed [MAG_W-1:0]   r_xx, r_xy;
    logic [MAG_W-1:0]          r_stmp;
    logic [MAG_W-1:0]          r_prod;
    t_ptag                     r_ptag, n_ptag;
    logic signed [WIDE_W-1:0]  r_acc, r_det, r_numi, r_nums;
    logic signed [VAL_W-1:0]   r_pred;
    logic                      r_pvalid;
    t_status                   r_status;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      in_fire, cfg_wr, div_start, out_load;
    logic [MUL_W-1:0]          mul_a, mul_b;
    logic signed [VAL_W-1:0]   eff_slope, eff_icpt;
    logic [DISC_W-1:0]         disc_eff;
    logic signed [WIDE_W-1:0]  div_n, div_d;
    t_div_res                  div_res;
    t_wstep                    ws;
    logic [MAG_W-1:0]          ma, mb;
    logic signed [MAG_W-1:0]   sa, sb;
    logic [2:0]                sc_idx;
    logic signed [MAG_W-1:0]   sc_sum;
    logic [MAG_W-1:0]          sc_mag;
    logic signed [VAL_W:0]     px_diff;
    logic signed [VAL_W-1:0]   pclamp;

    // consume side
    logic [MAG_W-1:0]          prod_neg, scaled_u;
    logic signed [MAG_W-1:0]   scaled, term;
    logic signed [MAG_W:0]     sat_sum;
    logic signed [ACC_WIDTH-1:0] sum_new;
    logic [WIDE_W-1:0]         part;
    logic signed [WIDE_W-1:0]  acc_next;
    logic signed [MAG_W:0]     py_prod;
    logic signed [MAG_W+1:0]   py_sum;
    logic signed [VAL_W-1:0]   py_val;

    function automatic logic signed [MAG_W-1:0] sum_at(input logic [2:0] idx);
        logic signed [MAG_W-1:0] v;
        case (idx)
            SI_W:    v = MAG_W'(r_wsum);
            SI_X:    v = MAG_W'(r_xsum);
            SI_Y:    v = MAG_W'(r_ysum);
            SI_XX:   v = MAG_W'(r_xxsum);
            SI_XY:   v = MAG_W'(r_xysum);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] mag64(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MUL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign eff_slope  = r_lock ? r_locked_slope : r_lslope;
    assign eff_icpt   = r_lock ? r_locked_icpt : r_licpt;
    assign disc_eff   = (r_discount > DISC_ONE) ? DISC_ONE : r_discount;
    assign px_diff    = (VAL_W+1)'(r_in.y_value) - (VAL_W+1)'(eff_icpt);

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_DISCOUNT: prdata = PDATA_W'(r_discount);
            REG_LOCK:     prdata = PDATA_W'(r_lock);
            REG_SLOPE:    prdata = r_locked_slope;
            REG_ICPT:     prdata = r_locked_icpt;
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        div_start = 1'b0;
        out_load  = 1'b0;
        div_n     = WIDE_W'(px_diff) <<< FRAC_BITS;
        div_d     = WIDE_W'(eff_slope);
        case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_cnt = '0;
                case (r_in.op)
                    OP_ADD:     n_state = r_lock ? ST_FINISH : ST_TERMS;
                    OP_PRED_Y:  n_state = ST_PRED_MUL;
                    OP_PRED_X,
                    OP_PRED_XC: n_state = (eff_slope == '0) ? ST_FINISH : ST_PRED_DIV;
                    default:    n_state = ST_FINISH;
                endcase
            end
            ST_TERMS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TERM_ISSUES - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCALE_ISSUES - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_WIDE;
                end
            end
            ST_WIDE: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDE_ISSUES - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = (r_det == '0) ? ST_FINISH : ST_DIV_ICPT;
            ST_DIV_ICPT: begin
                div_start = 1'b1;
                div_n     = r_numi <<< FRAC_BITS;
                div_d     = r_det;
                n_state   = ST_WAIT_ICPT;
            end
            ST_WAIT_ICPT: begin
                if (div_res.done) n_state = ST_DIV_SLOPE;
            end
            ST_DIV_SLOPE: begin
                div_start = 1'b1;
                div_n     = r_nums <<< FRAC_BITS;
                div_d     = r_det;
                n_state   = ST_WAIT_SLOPE;
            end
            ST_WAIT_SLOPE: begin
                if (div_res.done) n_state = ST_FINISH;
            end
            ST_PRED_MUL: n_state = ST_PRED_ADD;
            ST_PRED_ADD: n_state = ST_FINISH;
            ST_PRED_DIV: begin
                div_start = 1'b1;
                n_state   = ST_WAIT_PRED;
            end
            ST_WAIT_PRED: begin
                if (div_res.done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- multiplier issue ----------------
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        n_ptag = '0;
        ws     = wide_step(r_cnt[4:2]);
        sa     = sum_at(ws.a_idx);
        sb     = sum_at(ws.b_idx);
        ma     = mag64(sa);
        mb     = mag64(sb);
        sc_idx = r_cnt[3:1];
        sc_sum = sum_at(sc_idx);
        sc_mag = mag64(sc_sum);
        case (r_state)
            ST_TERMS: begin
                mul_a        = mag32(r_in.x_value);
                mul_b        = r_cnt[0] ? mag32(r_in.y_value) : mag32(r_in.x_value);
                n_ptag.valid = 1'b1;
                n_ptag.kind  = PK_TERM;
                n_ptag.idx   = {2'b00, r_cnt[0]};
                n_ptag.neg   = r_cnt[0] & (r_in.x_value[VAL_W-1] ^ r_in.y_value[VAL_W-1]);
            end
            ST_SCALE: begin
                // low half then high half of |sum| times the discount
                mul_a        = r_cnt[0] ? sc_mag[MAG_W-1:MUL_W] : sc_mag[MUL_W-1:0];
                mul_b        = MUL_W'(disc_eff);
                n_ptag.valid = 1'b1;
                n_ptag.kind  = PK_SCALE;
                n_ptag.idx   = sc_idx;
                n_ptag.half  = r_cnt[0];
                n_ptag.neg   = sc_sum[MAG_W-1];
            end
            ST_WIDE: begin
                mul_a        = r_cnt[1] ? ma[MAG_W-1:MUL_W] : ma[MUL_W-1:0];
                mul_b        = r_cnt[0] ? mb[MAG_W-1:MUL_W] : mb[MUL_W-1:0];
                n_ptag.valid = 1'b1;
                n_ptag.kind  = PK_WIDE;
                n_ptag.idx   = {1'b0, ws.dest};
                n_ptag.last  = ws.last && (r_cnt[1:0] == 2'b11);
                n_ptag.neg   = sa[MAG_W-1] ^ sb[MAG_W-1] ^ ws.sub;
                n_ptag.shift = (r_cnt[1] ? SH_W'(MUL_W) : '0)
                             + (r_cnt[0] ? SH_W'(MUL_W) : '0)
                             + (ws.fshift ? SH_W'(FRAC_BITS) : '0);
            end
            ST_PRED_MUL: begin
                mul_a        = mag32(eff_slope);
                mul_b        = mag32(r_in.x_value);
                n_ptag.valid = 1'b1;
                n_ptag.kind  = PK_PRED;
                n_ptag.neg   = eff_slope[VAL_W-1] ^ r_in.x_value[VAL_W-1];
            end
            default: ;
        endcase
    end

    // ---------------- product consume ----------------
    always_comb begin
        prod_neg = ~r_prod + 1'b1;
        scaled_u = (r_prod << DISC_FRAC) + r_stmp;
        scaled   = r_ptag.neg ? (~scaled_u + 1'b1) : scaled_u;
        case (r_ptag.idx)
            SI_W:    term = MAG_W'(1) << FRAC_BITS;
            SI_X:    term = MAG_W'(r_in.x_value);
            SI_Y:    term = MAG_W'(r_in.y_value);
            SI_XX:   term = r_xx;
            SI_XY:   term = r_xy;
            default: term = '0;
        endcase
        sat_sum = (MAG_W+1)'(scaled) + (MAG_W+1)'(term);
        if (sat_sum > ACC_MAX) begin
            sum_new = ACC_WIDTH'(ACC_MAX);
        end else if (sat_sum < ACC_MIN) begin
            sum_new = ACC_WIDTH'(ACC_MIN);
        end else begin
            sum_new = ACC_WIDTH'(sat_sum);
        end

        part     = WIDE_W'(r_prod) << r_ptag.shift;
        acc_next = r_ptag.neg ? (r_acc - part) : (r_acc + part);

        py_prod = r_ptag.neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        py_sum  = (MAG_W+2)'(py_prod >>> FRAC_BITS) + (MAG_W+2)'(eff_icpt);
        if (py_sum > V_MAX) begin
            py_val = VAL_W'(V_MAX);
        end else if (py_sum < V_MIN) begin
            py_val = VAL_W'(V_MIN);
        end else begin
            py_val = VAL_W'(py_sum);
        end

        // max limit is tested first when the limits cross
        pclamp = div_res.quot;
        if (r_in.op == OP_PRED_XC) begin
            if (div_res.quot > r_in.max_limit) begin
                pclamp = r_in.max_limit;
            end else if (div_res.quot < r_in.min_limit) begin
                pclamp = r_in.min_limit;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= MAG_W'(mul_a) * MAG_W'(mul_b);
        if (!i_rst_n) begin
            r_discount     <= DISC_RESET;
            r_lock         <= 1'b0;
            r_locked_slope <= '0;
            r_locked_icpt  <= '0;
            r_wsum         <= '0;
            r_xsum         <= '0;
            r_ysum         <= '0;
            r_xxsum        <= '0;
            r_xysum        <= '0;
            r_lslope       <= '0;
            r_licpt        <= '0;
            r_acc          <= '0;
            r_ptag         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_ptag <= n_ptag;

            if (cfg_wr) begin
                case (t_reg'(paddr[3:2]))
                    REG_DISCOUNT: r_discount     <= pwdata[DISC_W-1:0];
                    REG_LOCK:     r_lock         <= pwdata[0];
                    REG_SLOPE:    r_locked_slope <= pwdata;
                    REG_ICPT:     r_locked_icpt  <= pwdata;
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_in     <= i_in_item;
                r_pred   <= '0;
                r_pvalid <= 1'b0;
                r_status <= FS_NO_READING;
            end

            if (r_state == ST_DECODE) begin
                if (r_in.op == OP_ADD) begin
                    r_status <= r_lock ? FS_LOCKED : FS_UPDATED;
                end else if (r_in.op == OP_CLEAR) begin
                    r_wsum   <= '0;
                    r_xsum   <= '0;
                    r_ysum   <= '0;
                    r_xxsum  <= '0;
                    r_xysum  <= '0;
                    r_lslope <= '0;
                    r_licpt  <= '0;
                end
            end

            if (r_state == ST_DRAIN && r_det == '0) r_status <= FS_SINGULAR;

            if (r_ptag.valid) begin
                case (r_ptag.kind)
                    PK_TERM: begin
                        if (r_ptag.idx[0]) begin
                            r_xy <= r_ptag.neg ? prod_neg : r_prod;
                        end else begin
                            r_xx <= r_prod;
                        end
                    end
                    PK_SCALE: begin
                        if (!r_ptag.half) begin
                            r_stmp <= r_prod >> DISC_FRAC;
                        end else begin
                            case (r_ptag.idx)
                                SI_W:    r_wsum  <= sum_new;
                                SI_X:    r_xsum  <= sum_new;
                                SI_Y:    r_ysum  <= sum_new;
                                SI_XX:   r_xxsum <= sum_new;
                                SI_XY:   r_xysum <= sum_new;
                                default: ;
                            endcase
                        end
                    end
                    PK_WIDE: begin
                        if (r_ptag.last) begin
                            r_acc <= '0;
                            case (t_dest'(r_ptag.idx[1:0]))
                                DST_DET:  r_det  <= acc_next;
                                DST_NUMI: r_numi <= acc_next;
                                DST_NUMS: r_nums <= acc_next;
                                default: ;
                            endcase
                        end else begin
                            r_acc <= acc_next;
                        end
                    end
                    PK_PRED: begin
                        r_pred   <= py_val;
                        r_pvalid <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (div_res.done) begin
                case (r_state)
                    ST_WAIT_ICPT:  r_licpt  <= div_res.quot;
                    ST_WAIT_SLOPE: r_lslope <= div_res.quot;
                    ST_WAIT_PRED: begin
                        r_pred   <= pclamp;
                        r_pvalid <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (out_load) begin
            r_out <= '{fit_slope: eff_slope, fit_intercept: eff_icpt, prediction: r_pred,
                       prediction_valid: r_pvalid, fit_status: r_status};
        end
    end

    dlf_div #(
        .WIDE_W (WIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_res   (div_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_res.busy)
        else $error("divider started while busy");

    a_acc_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_acc == '0))
        else $error("accumulator not cleared between items");

    a_tag_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptag.valid |-> (r_state != ST_IDLE))
        else $error("product still in flight while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

    a_finish_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && !i_out_ready) |=> (r_state == ST_FINISH))
        else $error("item finished into a full output register");

endmodule
